>>> rtl/core/q2e_pkg.sv
package q2e_pkg;

  // default number of micro-rotations
  localparam int unsigned CordicStages = 16;
  localparam int unsigned AngTabLen    = 24;

  // bit-serial square root: one result bit per cell
  localparam int unsigned SqrtSteps = 31;

  localparam int unsigned ArgW = 34;
  localparam int unsigned VecW = 37;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } q2e_in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } q2e_out_t;

  // arguments riding alongside the square root
  typedef struct packed {
    logic signed [ArgW-1:0] ra;
    logic signed [ArgW-1:0] rb;
    logic signed [ArgW-1:0] ya;
    logic signed [ArgW-1:0] yb;
    logic signed [ArgW-1:0] s;
    logic                   clamped;
  } q2e_side_t;

  typedef struct packed {
    logic signed [61:0] n;
    logic        [61:0] root;
    q2e_side_t          side;
  } q2e_sqrt_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic        [31:0]     acc;
    logic                   zero;
  } q2e_vec_t;

  // lane 0 roll, lane 1 pitch, lane 2 yaw
  typedef struct packed {
    q2e_vec_t [2:0] lane;
    logic           clamped;
  } q2e_cordic_t;

  // atan(2^-i) in units of 2^-32 of a full turn
  function automatic logic [31:0] atan_angle(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/quaternion_to_euler.sv
// quaternion_to_euler: ZYX roll, pitch and yaw from a Q1.15 quaternion.
//
// Input channel: in_valid_i / in_ready_o carry one quaternion request
// (w, x, y, z). Output channel: out_valid_o / out_ready_i carry the three
// binary angles (32768 = pi) and the pitch saturation flag.
//
// Accepts one quaternion per cycle while in_ready_o is high. An accepted
// request passes through the registers of products, sums and the squared
// arcsine argument, 31 cells of the bit-serial square root, the quadrant
// folding register, one cell per micro-rotation, and the output register.
//
// Reset clears every valid bit; nothing else needs a reset.
// When the receiver stalls, the result is held in the output register and
// one more result goes to a skid register. The pipeline freezes only while
// the skid register is full, and in_ready_o is low only then.
module quaternion_to_euler #(
  parameter int unsigned CORDIC_STAGES = q2e_pkg::CordicStages
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  q2e_pkg::q2e_in_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output q2e_pkg::q2e_out_t  out_req_o
);

  localparam int unsigned AW = q2e_pkg::ArgW;
  localparam int unsigned VW = q2e_pkg::VecW;
  localparam int unsigned NS = q2e_pkg::SqrtSteps;

  logic en;

  // stage 1: products
  logic               v1_q;
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q, p_wy_q, p_zx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= in_req_i.quat_w * in_req_i.quat_x;
      p_yz_q <= in_req_i.quat_y * in_req_i.quat_z;
      p_xx_q <= in_req_i.quat_x * in_req_i.quat_x;
      p_yy_q <= in_req_i.quat_y * in_req_i.quat_y;
      p_wz_q <= in_req_i.quat_w * in_req_i.quat_z;
      p_xy_q <= in_req_i.quat_x * in_req_i.quat_y;
      p_zz_q <= in_req_i.quat_z * in_req_i.quat_z;
      p_wy_q <= in_req_i.quat_w * in_req_i.quat_y;
      p_zx_q <= in_req_i.quat_z * in_req_i.quat_x;
    end
  end

  // stage 2: arguments and arcsine saturation
  localparam logic signed [AW-1:0] OneQ30 = AW'(1) <<< 30;

  logic                 v2_q;
  q2e_pkg::q2e_side_t   side_d, side_q;
  logic [30:0]          s_mag_d, s_mag_q;
  logic signed [AW-1:0] s_raw;

  always_comb begin
    side_d.ra = (AW'(p_wx_q) + AW'(p_yz_q)) <<< 1;
    side_d.rb = OneQ30 - ((AW'(p_xx_q) + AW'(p_yy_q)) <<< 1);
    side_d.ya = (AW'(p_wz_q) + AW'(p_xy_q)) <<< 1;
    side_d.yb = OneQ30 - ((AW'(p_yy_q) + AW'(p_zz_q)) <<< 1);
    s_raw     = (AW'(p_wy_q) - AW'(p_zx_q)) <<< 1;
    if (s_raw > OneQ30) begin
      side_d.s       = OneQ30;
      side_d.clamped = 1'b1;
    end else if (s_raw < -OneQ30) begin
      side_d.s       = -OneQ30;
      side_d.clamped = 1'b1;
    end else begin
      side_d.s       = s_raw;
      side_d.clamped = 1'b0;
    end
    s_mag_d = side_d.s[AW-1] ? 31'(-side_d.s) : 31'(side_d.s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q  <= side_d;
      s_mag_q <= s_mag_d;
    end
  end

  // stage 3: radicand 1 - s^2 in Q.60
  logic               v3_q;
  q2e_pkg::q2e_sqrt_t sq_q;
  logic [61:0]        s_sq;

  assign s_sq = 62'(s_mag_q) * 62'(s_mag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q.n    <= $signed((62'd1 << 60) - s_sq);
      sq_q.root <= '0;
      sq_q.side <= side_q;
    end
  end

  // square root chain
  logic               sv  [NS+1];
  q2e_pkg::q2e_sqrt_t sd  [NS+1];

  assign sv[0] = v3_q;
  assign sd[0] = sq_q;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    q2e_sqrt_cell #(
      .STEP(g)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (en),
      .valid_i(sv[g]),
      .data_i (sd[g]),
      .valid_o(sv[g+1]),
      .data_o (sd[g+1])
    );
  end

  // quadrant folding into the vectoring lanes
  function automatic q2e_pkg::q2e_vec_t fold(input logic signed [AW-1:0] a,
                                              input logic signed [AW-1:0] b);
    q2e_pkg::q2e_vec_t v;
    v.zero = (a == '0) && (b == '0);
    if (b[AW-1]) begin
      v.x   = -VW'(b);
      v.y   = -VW'(a);
      v.acc = 32'h8000_0000;
    end else begin
      v.x   = VW'(b);
      v.y   = VW'(a);
      v.acc = 32'h0;
    end
    return v;
  endfunction

  logic                 vp_q;
  q2e_pkg::q2e_cordic_t pre_q;
  logic signed [AW-1:0] c_arg;

  assign c_arg = $signed(AW'(sd[NS].root[30:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= sv[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q.lane[0] <= fold(sd[NS].side.ra, sd[NS].side.rb);
      pre_q.lane[1] <= fold(sd[NS].side.s, c_arg);
      pre_q.lane[2] <= fold(sd[NS].side.ya, sd[NS].side.yb);
      pre_q.clamped <= sd[NS].side.clamped;
    end
  end

  // micro-rotation chain
  logic                 cv [CORDIC_STAGES+1];
  q2e_pkg::q2e_cordic_t cd [CORDIC_STAGES+1];

  assign cv[0] = vp_q;
  assign cd[0] = pre_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    q2e_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (en),
      .valid_i(cv[g]),
      .data_i (cd[g]),
      .valid_o(cv[g+1]),
      .data_o (cd[g+1])
    );
  end

  // angle codes and pitch saturation
  function automatic logic [15:0] to_code(input q2e_pkg::q2e_vec_t v);
    logic [31:0] r;
    r = v.acc + 32'h8000;
    return v.zero ? 16'h0 : r[31:16];
  endfunction

  q2e_pkg::q2e_out_t  res;
  logic signed [15:0] pc;

  always_comb begin
    pc = $signed(to_code(cd[CORDIC_STAGES].lane[1]));
    if (pc > 16'sd16384) begin
      pc = 16'sd16384;
    end else if (pc < -16'sd16384) begin
      pc = -16'sd16384;
    end
    res.roll_angle    = $signed(to_code(cd[CORDIC_STAGES].lane[0]));
    res.pitch_angle   = pc;
    res.yaw_angle     = $signed(to_code(cd[CORDIC_STAGES].lane[2]));
    res.pitch_clamped = cd[CORDIC_STAGES].clamped;
  end

  // output register with skid stage
  logic              out_valid_q, skid_valid_q;
  q2e_pkg::q2e_out_t out_q, skid_q;
  logic              produce;

  assign en      = !skid_valid_q;
  assign produce = en && cv[CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (produce) begin
      skid_q <= res;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> rtl/core/q2e_sqrt_cell.sv
module q2e_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  q2e_pkg::q2e_sqrt_t  data_i,
  output logic                valid_o,
  output q2e_pkg::q2e_sqrt_t  data_o
);

  localparam logic [61:0] Bit = 62'd1 << (60 - 2 * STEP);

  logic               valid_q;
  q2e_pkg::q2e_sqrt_t data_d, data_q;
  logic [61:0]        trial;

  // one restoring step of the integer square root
  always_comb begin
    data_d = data_i;
    trial  = data_i.root + Bit;
    if (data_i.n >= $signed(trial)) begin
      data_d.n    = data_i.n - $signed(trial);
      data_d.root = (data_i.root >> 1) + Bit;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/q2e_cordic_cell.sv
module q2e_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  q2e_pkg::q2e_cordic_t  data_i,
  output logic                  valid_o,
  output q2e_pkg::q2e_cordic_t  data_o
);

  localparam logic [31:0] Ang = q2e_pkg::atan_angle(STAGE);

  logic                 valid_q;
  q2e_pkg::q2e_cordic_t data_d, data_q;

  // one micro-rotation on each of the three lanes
  always_comb begin
    data_d = data_i;
    for (int l = 0; l < 3; l++) begin
      if (!data_i.lane[l].y[q2e_pkg::VecW-1]) begin
        data_d.lane[l].x   = data_i.lane[l].x + (data_i.lane[l].y >>> STAGE);
        data_d.lane[l].y   = data_i.lane[l].y - (data_i.lane[l].x >>> STAGE);
        data_d.lane[l].acc = data_i.lane[l].acc + Ang;
      end else begin
        data_d.lane[l].x   = data_i.lane[l].x - (data_i.lane[l].y >>> STAGE);
        data_d.lane[l].y   = data_i.lane[l].y + (data_i.lane[l].x >>> STAGE);
        data_d.lane[l].acc = data_i.lane[l].acc - Ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/q2e_checker.sv
module q2e_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input q2e_pkg::q2e_out_t out_req_o,
  input logic              out_valid_o,
  input logic              out_ready_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // request side stalls only behind a full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // pitch stays within a quarter turn either way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.pitch_angle <= 16'sd16384) &&
                    (out_req_o.pitch_angle >= -16'sd16384))
    else $error("pitch out of range");

  // the skid stage frees up once the output is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o)
    else $error("skid stage not drained");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_req_o  (out_req_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i)
);
